[hdl/ps2_mouse_position_tracker_defines.svh]
// Assertion macros for the PS/2 mouse position tracker.
// Used by modules that include this header; no other dependencies.
`ifndef PS2_MOUSE_POSITION_TRACKER_DEFINES_SVH
`define PS2_MOUSE_POSITION_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define PS2MT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ps2mt assertion failed");
`define PS2MT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define PS2MT_ASSERT(lbl, prop)
`define PS2MT_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

[hdl/ps2mt_pkg.sv]
// Package for the PS/2 mouse position tracker: payload structs, constants,
// register indexes and coordinate helper functions. No dependencies.
package ps2mt_pkg;

  localparam int CoordBits = 12;
  localparam int PosBits   = 12;
  localparam int RegBits   = 12;
  localparam int CfgIdxBits = 1;
  // Working width for signed coordinate math: covers the register width,
  // the coordinate width, the 9-bit movement and a sign.
  localparam int WorkBits = ((CoordBits > RegBits) ? CoordBits : RegBits) + 2;

  localparam logic [CoordBits-1:0] CursorXRst = CoordBits'(400);
  localparam logic [CoordBits-1:0] CursorYRst = CoordBits'(300);
  localparam logic [RegBits-1:0]   ScreenWRst = RegBits'(800);
  localparam logic [RegBits-1:0]   ScreenHRst = RegBits'(600);

  // Flag byte bit positions
  localparam int FlagLeftBit   = 0;
  localparam int FlagRightBit  = 1;
  localparam int FlagMiddleBit = 2;
  localparam int FlagValidBit  = 3;
  localparam int FlagXSignBit  = 4;
  localparam int FlagYSignBit  = 5;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgScreenWidth  = CfgIdxBits'(0),
    CfgScreenHeight = CfgIdxBits'(1)
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ByteFlag = 2'd0,
    ByteDx   = 2'd1,
    ByteDy   = 2'd2
  } byte_idx_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       aux_flag;
  } ps2mt_in_t;

  typedef struct packed {
    logic [PosBits-1:0] pos_x;
    logic [PosBits-1:0] pos_y;
    logic               button_left;
    logic               button_right;
    logic               button_middle;
  } ps2mt_out_t;

  // Largest allowed coordinate for a screen size: a size of zero counts as
  // one, and sizes beyond the coordinate range saturate.
  function automatic logic signed [WorkBits-1:0] clamp_top(logic [RegBits-1:0] size);
    logic signed [WorkBits-1:0] sz;
    logic signed [WorkBits-1:0] lim;
    sz  = WorkBits'(size);
    lim = WorkBits'(1) <<< CoordBits;
    if (size == '0) begin
      sz = WorkBits'(1);
    end
    if (sz > lim) begin
      sz = lim;
    end
    return sz - WorkBits'(1);
  endfunction

  function automatic logic [CoordBits-1:0] clamp_coord(logic signed [WorkBits-1:0] v,
                                                       logic signed [WorkBits-1:0] top);
    logic signed [WorkBits-1:0] r;
    r = v;
    if (v < 0) begin
      r = '0;
    end else if (v > top) begin
      r = top;
    end
    return r[CoordBits-1:0];
  endfunction

endpackage

[hdl/ps2_mouse_position_tracker.sv]
// PS/2 mouse position tracker: assembles 3-byte mouse packets and updates a
// clamped cursor. Depends on ps2mt_pkg and ps2_mouse_position_tracker_defines.svh.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one request per
//   byte read from the controller: the data byte and the aux flag. Bytes
//   without the aux flag are dropped. Aux bytes are gathered as flag, X, Y.
//   On the third byte the counter returns to zero; a packet whose flag byte
//   has bit 3 clear is dropped silently, otherwise the cursor moves by +X and
//   -Y, is clamped to the screen, and one result request carries the new
//   position and the three buttons on out_valid_o / out_ready_i / out_data_o.
//   Config channel (cfg_valid_i / cfg_ready_o) writes screen width (index 0)
//   or height (index 1); it is always ready. Write only while idle.
// Flow:
//   A byte lands in the input register at acceptance and is decoded in the
//   next cycle; a result then shows from the result register. One byte per cycle
//   unless a completing packet waits on a full result register: the decode and
//   clamp are one add and compare per axis between the input and result registers.
// Reset: cursor 400/300, buttons clear, packet counter zero, screen 800x600.
// Stall: the result register holds until taken; the input register keeps
//   moving unless it holds a completing packet and the result is still full,
//   in which case in_ready_o drops until the receiver takes the result.
`include "ps2_mouse_position_tracker_defines.svh"

module ps2_mouse_position_tracker
  import ps2mt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ps2mt_in_t             in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ps2mt_out_t            out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [RegBits-1:0]    cfg_data_i
);

  // Input register
  logic      s1_valid_q, s1_valid_d;
  ps2mt_in_t s1_q;

  // Packet state
  logic [1:0]           idx_q, idx_d;
  logic [7:0]           flag_q, flag_d;
  logic [7:0]           dx_q, dx_d;
  logic [CoordBits-1:0] cursor_x_q, cursor_x_d;
  logic [CoordBits-1:0] cursor_y_q, cursor_y_d;

  // Screen size registers
  logic [RegBits-1:0] scr_w_q, scr_h_q;

  // Result register
  logic       out_valid_q, out_valid_d;
  ps2mt_out_t out_q, out_d;

  logic out_free;
  logic produce;
  logic s1_fire;
  logic out_load;

  logic signed [WorkBits-1:0] dx, dy, vx, vy, top_x, top_y;

  assign cfg_ready_o = 1'b1;

  // A completing, valid packet needs the result slot.
  assign produce  = s1_q.aux_flag && (idx_q != ByteFlag) && (idx_q != ByteDx)
                    && flag_q[FlagValidBit];
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_fire  = s1_valid_q && (!produce || out_free);
  assign out_load = s1_fire && produce;
  assign in_ready_o = !s1_valid_q || s1_fire;

  assign s1_valid_d = (in_valid_i && in_ready_o) || (s1_valid_q && !s1_fire);

  // Movement decode and clamp
  assign dx    = WorkBits'($signed({flag_q[FlagXSignBit], dx_q}));
  assign dy    = WorkBits'($signed({flag_q[FlagYSignBit], s1_q.rx_byte}));
  assign vx    = $signed(WorkBits'(cursor_x_q)) + dx;
  assign vy    = $signed(WorkBits'(cursor_y_q)) - dy;
  assign top_x = clamp_top(scr_w_q);
  assign top_y = clamp_top(scr_h_q);

  // Packet assembly: advance the byte counter on every aux byte.
  always_comb begin
    idx_d      = idx_q;
    flag_d     = flag_q;
    dx_d       = dx_q;
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (s1_fire && s1_q.aux_flag) begin
      unique case (idx_q)
        ByteFlag: begin
          flag_d = s1_q.rx_byte;
          idx_d  = ByteDx;
        end
        ByteDx: begin
          dx_d  = s1_q.rx_byte;
          idx_d = ByteDy;
        end
        default: begin
          // Third byte closes the packet; drop it if the flag is invalid.
          idx_d = ByteFlag;
          if (flag_q[FlagValidBit]) begin
            cursor_x_d = clamp_coord(vx, top_x);
            cursor_y_d = clamp_coord(vy, top_y);
          end
        end
      endcase
    end
  end

  // Result register: load on a completed packet, drop when taken.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d         = 1'b1;
      out_d.pos_x         = PosBits'(cursor_x_d);
      out_d.pos_y         = PosBits'(cursor_y_d);
      out_d.button_left   = flag_q[FlagLeftBit];
      out_d.button_right  = flag_q[FlagRightBit];
      out_d.button_middle = flag_q[FlagMiddleBit];
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      idx_q       <= ByteFlag;
      flag_q      <= '0;
      dx_q        <= '0;
      cursor_x_q  <= CursorXRst;
      cursor_y_q  <= CursorYRst;
      scr_w_q     <= ScreenWRst;
      scr_h_q     <= ScreenHRst;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      idx_q       <= idx_d;
      flag_q      <= flag_d;
      dx_q        <= dx_d;
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgScreenWidth:  scr_w_q <= cfg_data_i;
          CfgScreenHeight: scr_h_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Input payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions
  `PS2MT_ASSERT(a_idx_range, idx_q != 2'd3)
  `PS2MT_ASSERT_MSG(a_load_shows, out_load |=> out_valid_q, "completed packet not shown")
  `PS2MT_ASSERT_MSG(a_x_clamped, out_load |=> ($signed(WorkBits'(cursor_x_q)) <= $past(top_x)),
                    "cursor x beyond screen")
  `PS2MT_ASSERT_MSG(a_y_clamped, out_load |=> ($signed(WorkBits'(cursor_y_q)) <= $past(top_y)),
                    "cursor y beyond screen")
  `PS2MT_ASSERT_MSG(a_cursor_hold, !out_load |=> ($stable(cursor_x_q) && $stable(cursor_y_q)),
                    "cursor moved without a result")
  `PS2MT_ASSERT(a_stall_cause, !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))

endmodule

[tb/ps2mt_checker.sv]
// Scoreboard for the PS/2 mouse position tracker: watches the byte, result
// and register-write channels, predicts each cursor report and compares.
// Depends on ps2mt_pkg for the payload structs, register indexes and widths.
`timescale 1ns / 100ps

module ps2mt_checker
  import ps2mt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  ps2mt_in_t             in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  ps2mt_out_t            out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [RegBits-1:0]    cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic [RegBits-1:0]   cols_q;
  logic [RegBits-1:0]   rows_q;
  byte_idx_e            slot_q;
  logic [7:0]           flag_q;
  logic [7:0]           dx_q;
  logic [CoordBits-1:0] col_q;
  logic [CoordBits-1:0] row_q;

  ps2mt_out_t cursor_reports[$];
  int         mismatches = 0;
  int         backlog = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = backlog;

  // Size zero behaves as one; the top saturates at the coordinate range.
  function automatic logic [CoordBits-1:0] fit_to_screen(input int pos,
                                                         input logic [RegBits-1:0] size);
    int top_pos;
    int fitted;
    top_pos = (size == '0) ? 0 : int'(size) - 1;
    if (top_pos > (1 << CoordBits) - 1) top_pos = (1 << CoordBits) - 1;
    fitted = pos;
    if (fitted < 0) fitted = 0;
    else if (fitted > top_pos) fitted = top_pos;
    return fitted[CoordBits-1:0];
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  task automatic take_mouse_byte(input ps2mt_in_t item);
    ps2mt_out_t        report;
    logic signed [8:0] dx_move;
    logic signed [8:0] dy_move;
    if (!item.aux_flag) return;
    case (slot_q)
      ByteFlag: begin
        flag_q = item.rx_byte;
        slot_q = ByteDx;
      end
      ByteDx: begin
        dx_q   = item.rx_byte;
        slot_q = ByteDy;
      end
      default: begin
        slot_q = ByteFlag;
        if (flag_q[FlagValidBit]) begin
          dx_move = {flag_q[FlagXSignBit], dx_q};
          dy_move = {flag_q[FlagYSignBit], item.rx_byte};
          col_q = fit_to_screen(int'(col_q) + int'(dx_move), cols_q);
          row_q = fit_to_screen(int'(row_q) - int'(dy_move), rows_q);
          report.pos_x         = PosBits'(col_q);
          report.pos_y         = PosBits'(row_q);
          report.button_left   = flag_q[FlagLeftBit];
          report.button_right  = flag_q[FlagRightBit];
          report.button_middle = flag_q[FlagMiddleBit];
          cursor_reports.push_back(report);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ps2mt_out_t want;
    if (!rst_ni) begin
      cols_q = ScreenWRst;
      rows_q = ScreenHRst;
      slot_q = ByteFlag;
      flag_q = '0;
      dx_q   = '0;
      col_q  = CursorXRst;
      row_q  = CursorYRst;
      cursor_reports.delete();
      backlog = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgScreenWidth) cols_q = cfg_data_i;
        else if (cfg_index_i == CfgScreenHeight) rows_q = cfg_data_i;
      end
      // Compare before predicting: a byte never yields a result on its own edge.
      if (out_valid_i && out_ready_i) begin
        if (cursor_reports.size() == 0) begin
          $error("unexpected result: pos_x %0d pos_y %0d", out_data_i.pos_x,
                 out_data_i.pos_y);
          mismatches++;
        end else begin
          want = cursor_reports.pop_front();
          check_field("pos_x", want.pos_x, out_data_i.pos_x);
          check_field("pos_y", want.pos_y, out_data_i.pos_y);
          check_field("button_left", want.button_left, out_data_i.button_left);
          check_field("button_right", want.button_right, out_data_i.button_right);
          check_field("button_middle", want.button_middle, out_data_i.button_middle);
        end
      end
      if (in_valid_i && in_ready_i) take_mouse_byte(in_data_i);
      backlog = cursor_reports.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the PS/2 mouse position tracker: clock, reset, byte and
// register-write stimulus, result back-pressure and the verdict.
// Depends on ps2mt_pkg, the tracker RTL and ps2mt_checker.
`timescale 1ns / 100ps

module tb_top;
  import ps2mt_pkg::*;

  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 250;
  // Cycles to let a dropped packet drain out of the pipeline before a write.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 500000;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_valid;
  logic                  in_ready;
  ps2mt_in_t             in_data;
  logic                  out_valid;
  logic                  out_ready;
  ps2mt_out_t            out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [RegBits-1:0]    cfg_data;

  int fail_count;
  int pending;

  // Shared knobs between the sender and the receiver process.
  bit idling_on = 1'b1;
  bit hold_out  = 1'b0;

  // Position of the next mouse byte within a packet, as the sender sees it.
  int aux_phase = 0;
  int items_sent;
  int unsigned cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ps2_mouse_position_tracker u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ps2mt_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Give up on a hung run; the limit is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result receiver: random ready bursts, plus one long hold-off on demand.
  // Drive ready once per falling edge so the edge never sees two updates.
  initial begin
    int run_left;
    run_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        // Hold ready low and count the stretch here, so the block backs up
        // while the sender keeps offering bytes.
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_out = 1'b0;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (idling_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        run_left = $urandom_range(0, 9);
      end else begin
        out_ready <= 1'b1;
        run_left = $urandom_range(0, 9);
      end
    end
  end

  // Offer one byte request and hold it until accepted. Valid stays high on
  // return, so only a random idle gap drops it between back-to-back requests.
  task automatic send_byte(input logic [7:0] value, input logic from_aux);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: value, aux_flag: from_aux};
    do @(posedge clk); while (!in_ready);
    if (from_aux) aux_phase = (aux_phase + 1) % 3;
  endtask

  // Send flag, X and Y as mouse bytes; optionally slip one controller byte
  // (no aux flag) in front of byte number noise_at.
  task automatic send_packet(input logic [7:0] flag, input logic [7:0] dx,
                             input logic [7:0] dy, input int noise_at);
    logic [7:0] packet_bytes [3];
    packet_bytes[0] = flag;
    packet_bytes[1] = dx;
    packet_bytes[2] = dy;
    for (int k = 0; k < 3; k++) begin
      if (k == noise_at) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(packet_bytes[k], 1'b1);
    end
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both screen registers as two back-to-back requests.
  task automatic write_screen(input logic [RegBits-1:0] cols,
                              input logic [RegBits-1:0] rows);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CfgScreenWidth;
    cfg_data  <= cols;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CfgScreenHeight;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] flag;
    int         pick;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgScreenWidth;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed part on the reset screen (800 x 600).
    // Controller bytes with no aux flag: ignored, extremes of the byte.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // Valid flag, no movement.
    send_packet(8'h08, 8'h00, 8'h00, -1);
    // All buttons, largest positive moves.
    send_packet(8'h0F, 8'hFF, 8'hFF, -1);
    // Both sign bits with zero bytes: the most negative moves.
    send_packet(8'h38, 8'h00, 8'h00, -1);
    // Flag with bit 3 clear: packet dropped, cursor stays.
    send_packet(8'hF7, 8'h55, 8'hAA, -1);
    // Overflow bits set (ignored) and a controller byte inside the packet.
    send_packet(8'hC9, 8'h7F, 8'h80, 1);
    // Push the row down by the full negative Y move.
    send_packet(8'h28, 8'hFF, 8'h00, -1);

    for (int phase = 0; phase < PHASES; phase++) begin
      // Every phase starts from an idle block: all results in, pipe empty.
      settle_block();
      case (phase)
        1: begin
          write_screen(12'd4095, 12'd4095);
          // Stall the receiver for a long stretch while bytes keep coming.
          hold_out = 1'b1;
        end
        2: write_screen(12'd0, 12'd0);
        3: write_screen(12'd1, 12'd4095);
        4: write_screen(12'd37, 12'd23);
        5: write_screen(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
        6: begin
          write_screen(12'd640, 12'd480);
          // Final stretch runs at full rate on both sides.
          idling_on = 1'b0;
        end
        default: begin
        end
      endcase

      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          // Noise byte from the controller, not from the mouse.
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick == 1) begin
          // Stray mouse byte: knocks the packet framing out of step.
          send_byte(8'($urandom_range(0, 255)), 1'b1);
          items_sent++;
        end else begin
          // Finish any broken packet so the next one lines up.
          while (aux_phase != 0) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            items_sent++;
          end
          flag = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 9) != 0) flag[FlagValidBit] = 1'b1;
          send_packet(flag, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 2)) : -1);
          items_sent += 3;
        end
      end
    end

    settle_block();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
